/* hdl/integer_to_ascii_formatter_unit_defines.svh */
// assertion macros used by the formatter back end
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ITOAF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must never be seen
`define ITOAF_ASSERT_NEVER(label, clk, rst, bad, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(bad)) \
      else $error(msg);

`endif

/* hdl/itoaf_pkg.sv */
// types, constants and helper functions of the integer to ascii formatter
package itoaf_pkg;

   localparam int OP_WIDTH    = 3;
   localparam int VALUE_WIDTH = 64;
   localparam int HALF_WIDTH  = 32;
   localparam int CHAR_WIDTH  = 8;
   localparam int SIGN_WIDTH  = 2;
   localparam int NIBBLES     = VALUE_WIDTH / 4;
   localparam int POS_WIDTH   = $clog2(NIBBLES);
   localparam int BCD_DIGITS  = 10;
   localparam int BCD_WIDTH   = BCD_DIGITS * 4;
   localparam int STEP_WIDTH  = $clog2(HALF_WIDTH);

   typedef enum logic [OP_WIDTH-1:0] {
      OP_SIGNED_DEC   = 3'd0,
      OP_UNSIGNED_DEC = 3'd1,
      OP_HEX_LOWER    = 3'd2,
      OP_HEX_UPPER    = 3'd3,
      OP_POINTER      = 3'd4
   } op_type;

   localparam logic [SIGN_WIDTH-1:0] SIGN_UNTOUCHED = 2'd0;
   localparam logic [SIGN_WIDTH-1:0] SIGN_NEGATIVE  = 2'd1;
   localparam logic [SIGN_WIDTH-1:0] SIGN_ZERO      = 2'd2;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X       = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_A_LOWER = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_A_UPPER = 8'h41;

   // classified job handed from front to back
   typedef struct packed {
      logic                   is_dec;
      logic                   upper;
      logic                   prefix;
      logic [SIGN_WIDTH-1:0]  sign;
      logic [VALUE_WIDTH-1:0] mag;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CONVERT,
      BK_FIND,
      BK_PREFIX_ZERO,
      BK_PREFIX_X,
      BK_DIGITS
   } back_state_type;

   function automatic logic [CHAR_WIDTH-1:0] nibble_char(input logic [3:0] nib,
                                                         input logic upper);
      logic [CHAR_WIDTH-1:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         return CHAR_ZERO + wide;
      end else if (upper) begin
         return CHAR_A_UPPER + wide - 8'd10;
      end else begin
         return CHAR_A_LOWER + wide - 8'd10;
      end
   endfunction

   // index of the highest nonzero nibble, zero when all nibbles are zero
   function automatic logic [POS_WIDTH-1:0] msd_index(input logic [VALUE_WIDTH-1:0] d);
      logic [POS_WIDTH-1:0] idx;
      idx = '0;
      for (int i = 0; i < NIBBLES; i++) begin
         if (d[i*4 +: 4] != 4'h0) begin
            idx = POS_WIDTH'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* hdl/itoaf_ifs.sv */
// request and response channel interfaces of the formatter
interface itoaf_req_if;
   import itoaf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OP_WIDTH-1:0]    operation;
   logic [VALUE_WIDTH-1:0] value;
   modport source (output valid, output operation, output value, input ready);
   modport sink (input valid, input operation, input value, output ready);
endinterface

interface itoaf_rsp_if;
   import itoaf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] character;
   logic                  last;
   logic [SIGN_WIDTH-1:0] sign_code;
   modport source (output valid, output character, output last, output sign_code,
                   input ready);
   modport sink (input valid, input character, input last, input sign_code,
                 output ready);
endinterface

/* hdl/itoaf_front.sv */
// front end: accepts requests and classifies them into jobs
module itoaf_front (
   itoaf_req_if.sink          req,
   output itoaf_pkg::job_type job,
   output logic               job_valid,
   input  logic               job_ready
);
   import itoaf_pkg::*;

   logic [HALF_WIDTH-1:0] low;
   logic                  known;

   always_comb begin
      low        = req.value[HALF_WIDTH-1:0];
      known      = 1'b1;
      job.is_dec = 1'b0;
      job.upper  = 1'b0;
      job.prefix = 1'b0;
      job.sign   = SIGN_UNTOUCHED;
      job.mag    = {{(VALUE_WIDTH-HALF_WIDTH){1'b0}}, low};
      case (req.operation)
         OP_SIGNED_DEC: begin
            job.is_dec = 1'b1;
            if (low[HALF_WIDTH-1]) begin
               job.sign = SIGN_NEGATIVE;
               job.mag  = {{(VALUE_WIDTH-HALF_WIDTH){1'b0}}, (~low) + 32'd1};
            end
         end
         OP_UNSIGNED_DEC: begin
            job.is_dec = 1'b1;
         end
         OP_HEX_LOWER: begin
            job.upper = 1'b0;
         end
         OP_HEX_UPPER: begin
            job.upper = 1'b1;
         end
         OP_POINTER: begin
            job.prefix = 1'b1;
            job.mag    = req.value;
         end
         default: begin
            known = 1'b0;
         end
      endcase
      if (job.mag == '0) begin
         job.sign = SIGN_ZERO;
      end
   end

   // unused codes are taken and dropped
   assign job_valid = req.valid && known;
   assign req.ready = job_ready;

endmodule

/* hdl/itoaf_fifo.sv */
// short job queue between front and back
module itoaf_fifo #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  itoaf_pkg::job_type push_job,
   input  logic               push_valid,
   output logic               push_ready,
   output itoaf_pkg::job_type pop_job,
   output logic               pop_valid,
   input  logic               pop_ready
);
   import itoaf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hdl/itoaf_back.sv */
// back end: binary to bcd conversion and character emission
`include "integer_to_ascii_formatter_unit_defines.svh"
module itoaf_back (
   input  logic               clock,
   input  logic               reset,
   input  itoaf_pkg::job_type job,
   input  logic               job_valid,
   output logic               job_ready,
   itoaf_rsp_if.source        rsp
);
   import itoaf_pkg::*;

   back_state_type         state_ff, state_in;
   logic [VALUE_WIDTH-1:0] dig_ff, dig_in;
   logic [HALF_WIDTH-1:0]  bin_ff, bin_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic                   upper_ff, upper_in;
   logic                   prefix_ff, prefix_in;
   logic [SIGN_WIDTH-1:0]  sign_ff, sign_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                   last_ff, last_in;
   logic [SIGN_WIDTH-1:0]  code_ff, code_in;
   logic                   emit_ok;
   logic [BCD_WIDTH-1:0]   adj;
   logic [3:0]             cur_nib;

   assign emit_ok = !out_valid_ff || rsp.ready;
   assign cur_nib = dig_ff[{pos_ff, 2'b00} +: 4];

   // add three to every bcd digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[i*4 +: 4] = (dig_ff[i*4 +: 4] >= 4'd5) ? dig_ff[i*4 +: 4] + 4'd3
                                                    : dig_ff[i*4 +: 4];
      end
   end

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      bin_in       = bin_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      upper_in     = upper_ff;
      prefix_in    = prefix_ff;
      sign_in      = sign_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      code_in      = code_ff;
      job_ready    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               upper_in  = job.upper;
               prefix_in = job.prefix;
               sign_in   = job.sign;
               if (job.is_dec) begin
                  bin_in   = job.mag[HALF_WIDTH-1:0];
                  dig_in   = '0;
                  step_in  = '0;
                  state_in = BK_CONVERT;
               end else begin
                  dig_in   = job.mag;
                  state_in = BK_FIND;
               end
            end
         end
         BK_CONVERT: begin
            dig_in  = {{(VALUE_WIDTH-BCD_WIDTH){1'b0}}, adj[BCD_WIDTH-2:0],
                       bin_ff[HALF_WIDTH-1]};
            bin_in  = {bin_ff[HALF_WIDTH-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(HALF_WIDTH - 1)) begin
               state_in = BK_FIND;
            end
         end
         BK_FIND: begin
            pos_in   = msd_index(dig_ff);
            state_in = prefix_ff ? BK_PREFIX_ZERO : BK_DIGITS;
         end
         BK_PREFIX_ZERO: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               char_in      = CHAR_ZERO;
               last_in      = 1'b0;
               code_in      = sign_ff;
               state_in     = BK_PREFIX_X;
            end
         end
         BK_PREFIX_X: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               char_in      = CHAR_X;
               last_in      = 1'b0;
               code_in      = sign_ff;
               state_in     = BK_DIGITS;
            end
         end
         BK_DIGITS: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               char_in      = nibble_char(cur_nib, upper_ff);
               last_in      = (pos_ff == '0);
               code_in      = sign_ff;
               if (pos_ff == '0) begin
                  state_in = BK_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff    <= dig_in;
      bin_ff    <= bin_in;
      step_ff   <= step_in;
      pos_ff    <= pos_in;
      upper_ff  <= upper_in;
      prefix_ff <= prefix_in;
      sign_ff   <= sign_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      code_ff   <= code_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.character = char_ff;
   assign rsp.last      = last_ff;
   assign rsp.sign_code = code_ff;

   `ITOAF_ASSERT_IMPLIES(a_find_zero, clock, reset, state_ff == BK_FIND, (sign_ff == SIGN_ZERO) == (dig_ff == '0), "zero sign code disagrees with digits")
   `ITOAF_ASSERT_IMPLIES(a_zero_one_digit, clock, reset, state_ff == BK_DIGITS && sign_ff == SIGN_ZERO, pos_ff == '0, "zero value with more than one digit")
   `ITOAF_ASSERT_NEVER(a_bcd_range, clock, reset, state_ff == BK_CONVERT && dig_ff[VALUE_WIDTH-1:BCD_WIDTH] != '0, "bcd result beyond ten digits")

endmodule

/* hdl/integer_to_ascii_formatter_unit.sv */
// top level of the integer to ascii formatter
//
// channel   direction  payload                          transfer when
// req       in         operation[2:0], value[63:0]      req.valid && req.ready
// rsp       out        character[7:0], last, sign_code  rsp.valid && rsp.ready
//
// decimal items (1..10 digits) first pass the one-bit-per-cycle double
// dabble loop in the back end; hex items have 1..8 digits and pointer
// items 1..16 digits after a 0x prefix; while rsp is ready, the back end
// emits one character per cycle through its output register
// the queue lets the front take new requests while the back end is busy
// reset is synchronous and active high; it empties the queue and output
// a stalled rsp holds the back end but not the front until the queue fills
module integer_to_ascii_formatter_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic          clock,
   input logic          reset,
   itoaf_req_if.sink    req,
   itoaf_rsp_if.source  rsp
);
   import itoaf_pkg::*;

   // classified job out of the front end
   job_type front_job;
   logic    front_valid;
   logic    front_ready;

   // job at the head of the queue
   job_type back_job;
   logic    back_valid;
   logic    back_ready;

   // front: decode operation, take magnitude and sign code
   itoaf_front u_front (
      .req       (req),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (front_ready)
   );

   // short queue decouples classification from emission
   itoaf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_job   (front_job),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_job    (back_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready)
   );

   // back: bcd conversion for decimal, then characters msd first
   itoaf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (back_job),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .rsp       (rsp)
   );

endmodule
